FILE: sv/assert_macros.svh
// Assertion macros used by the RTL. They sample on clk_i and are
// disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, ante, cons, msg)

`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: sv/sv39ptw_pkg.sv
`default_nettype none

package sv39ptw_pkg;

  localparam int PPN_W     = 44;
  localparam int PA_W      = 56;
  localparam int VA_W      = 39;
  localparam int PTE_W     = 64;
  localparam int IDX_W     = 9;
  localparam int OFF_W     = 12;
  localparam int EIDX_W    = 12;
  localparam int VA_PAD_W  = OFF_W + 4 * IDX_W;
  localparam int PTE_PPN_LO = 10;
  localparam int FLAG_V    = 0;
  localparam int FLAG_U    = 4;

  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_USER   = 2'd1;
  localparam logic [1:0] MODE_KERNEL = 2'd2;

  localparam logic CFG_ROOT = 1'b0;
  localparam logic CFG_BASE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_VA_BIG   = 3'd1,
    ST_INVALID  = 3'd2,
    ST_NOT_USER = 3'd3,
    ST_OUTSIDE  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } walk_state_e;

  typedef struct packed {
    logic [PPN_W-1:0] root_ppn;
    logic [PPN_W-1:0] base_ppn;
  } cfg_t;

  typedef struct packed {
    logic            valid;
    logic [PA_W-1:0] phys_addr;
    status_e         status;
  } res_t;

endpackage

`default_nettype wire

FILE: sv/sv39ptw_req_if.sv
`default_nettype none

interface sv39ptw_req_if
  import sv39ptw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [VA_W-1:0]   virt_addr;
  logic [EIDX_W-1:0] entry_index;
  logic [PTE_W-1:0]  entry_data;

  modport source (output valid, output mode, output virt_addr, output entry_index,
                  output entry_data, input ready);
  modport sink (input valid, input mode, input virt_addr, input entry_index,
                input entry_data, output ready);
endinterface

`default_nettype wire

FILE: sv/sv39ptw_rsp_if.sv
`default_nettype none

interface sv39ptw_rsp_if
  import sv39ptw_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [PA_W-1:0] phys_addr;
  logic [2:0]      status;

  modport source (output valid, output phys_addr, output status, input ready);
  modport sink (input valid, input phys_addr, input status, output ready);
endinterface

`default_nettype wire

FILE: sv/sv39_page_table_walker.sv
// Channel  | Dir | Payload                                    | Handshake
// req_i    | in  | mode, virt_addr, entry_index, entry_data   | valid/ready
// rsp_o    | out | phys_addr, status                          | valid/ready
// cfg      | in  | cfg_idx_i, cfg_wdata_i                     | cfg_we_i
//
// A translation is accepted, walks the table with one dependent read per level
// of the registered table memory, and then returns its result from S_DONE.
// A write, a fault found at acceptance or an unused mode goes straight to S_DONE.
// After reset the table memory is cleared to zero; no word is
// accepted during that pass, while configuration writes are taken.
// A registered result stage lets the next word enter while a result is stalled.
`default_nettype none

`include "assert_macros.svh"

module sv39_page_table_walker
  import sv39ptw_pkg::*;
#(
  parameter int STORE_WORDS = 4096,
  parameter int LEVELS = 3
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  sv39ptw_req_if.sink           req_i,
  sv39ptw_rsp_if.source         rsp_o,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [PPN_W-1:0] cfg_wdata_i
);

  localparam int AW = $clog2(STORE_WORDS);

  cfg_t             cfg_q;
  res_t             res;
  logic             store_busy;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [PTE_W-1:0] wr_data;
  logic [PTE_W-1:0] rd_data;
  logic             out_free;
  logic             out_valid_q;
  logic [PA_W-1:0]  out_pa_q;
  status_e          out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROOT: cfg_q.root_ppn <= cfg_wdata_i;
        CFG_BASE: cfg_q.base_ppn <= cfg_wdata_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  sv39ptw_store #(
    .STORE_WORDS(STORE_WORDS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_data_o(rd_data),
    .busy_o   (store_busy)
  );

  sv39ptw_walk #(
    .STORE_WORDS(STORE_WORDS),
    .LEVELS     (LEVELS)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_i       (cfg_q),
    .store_busy_i(store_busy),
    .out_free_i  (out_free),
    .rd_data_i   (rd_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .res_o       (res)
  );

  assign out_free = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && out_free) begin
      out_pa_q <= res.phys_addr;
      out_st_q <= res.status;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.phys_addr = out_pa_q;
  assign rsp_o.status    = out_st_q;

  `ASSERT_NEVER(a_no_accept_in_clear, req_i.valid && req_i.ready && store_busy, "word accepted during clear")
  `ASSERT_NEVER(a_no_push_when_full, res.valid && out_valid_q && !rsp_o.ready, "result lost")
  `ASSERT_IMPLIES(a_fault_zero_pa, rsp_o.valid && (rsp_o.status != ST_OK), rsp_o.phys_addr == '0, "fault with address")

endmodule

`default_nettype wire

FILE: sv/sv39ptw_store.sv
`default_nettype none

module sv39ptw_store
  import sv39ptw_pkg::*;
#(
  parameter int STORE_WORDS = 4096,
  localparam int AW = $clog2(STORE_WORDS)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [PTE_W-1:0] wr_data_i,
  output logic      [PTE_W-1:0] rd_data_o,
  output logic                  busy_o
);

  logic [PTE_W-1:0] mem_q [STORE_WORDS];
  logic [PTE_W-1:0] rd_data_q;
  logic [AW-1:0]    clr_cnt_q;
  logic             clr_busy_q;

  // After reset the whole array is swept to zero, one word per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(STORE_WORDS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

`default_nettype wire

FILE: sv/sv39ptw_walk.sv
`default_nettype none

module sv39ptw_walk
  import sv39ptw_pkg::*;
#(
  parameter int STORE_WORDS = 4096,
  parameter int LEVELS = 3,
  localparam int AW = $clog2(STORE_WORDS)
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  sv39ptw_req_if.sink       req_i,
  input  wire cfg_t         cfg_i,
  input  wire logic         store_busy_i,
  input  wire logic         out_free_i,
  input  wire logic [PTE_W-1:0] rd_data_i,
  output logic              rd_en_o,
  output logic [AW-1:0]     rd_addr_o,
  output logic              wr_en_o,
  output logic [AW-1:0]     wr_addr_o,
  output logic [PTE_W-1:0]  wr_data_o,
  output res_t              res_o
);

  localparam int LvlW   = $clog2(LEVELS);
  localparam int VaBits = IDX_W * LEVELS + OFF_W - 1;
  localparam int WordW  = AW + IDX_W;
  localparam int EidxExtW = (AW > EIDX_W) ? AW : EIDX_W;

  walk_state_e      state_q, state_d;
  logic [LvlW-1:0]  lvl_q, lvl_d;
  logic [VA_W-1:0]  va_q, va_d;
  logic             user_q, user_d;
  logic [PA_W-1:0]  res_pa_q, res_pa_d;
  status_e          res_st_q, res_st_d;

  logic             push;
  logic             accept;
  logic [PTE_W-1:0] pte;
  logic [AW:0]      loc;
  logic [EidxExtW-1:0] widx_ext;

  function automatic logic [IDX_W-1:0] va_index(logic [VA_W-1:0] va,
                                                 logic [LvlW-1:0] lvl);
    logic [VA_PAD_W-1:0] pad;
    pad = VA_PAD_W'(va);
    return pad[OFF_W + IDX_W * lvl +: IDX_W];
  endfunction

  // Returns the hit flag above the store word address.
  function automatic logic [AW:0] locate(logic [PPN_W-1:0] pg, logic [IDX_W-1:0] idx,
                                         logic [PPN_W-1:0] base);
    logic [PPN_W-1:0] d;
    logic [WordW-1:0] w;
    logic             ok;
    d  = pg - base;
    w  = {d[AW-1:0], idx};
    ok = (pg >= base) && (d < PPN_W'(STORE_WORDS)) && (w < WordW'(STORE_WORDS));
    return {ok, w[AW-1:0]};
  endfunction

  assign push        = (state_q == S_DONE) && out_free_i;
  assign req_i.ready = !store_busy_i && ((state_q == S_IDLE) || push);
  assign accept      = req_i.valid && req_i.ready;
  assign pte         = rd_data_i;
  assign widx_ext    = EidxExtW'(req_i.entry_index);

  assign wr_addr_o = widx_ext[AW-1:0];
  assign wr_data_o = req_i.entry_data;

  always_comb begin
    state_d  = state_q;
    lvl_d    = lvl_q;
    va_d     = va_q;
    user_d   = user_q;
    res_pa_d = res_pa_q;
    res_st_d = res_st_q;
    rd_en_o  = 1'b0;
    rd_addr_o = '0;
    wr_en_o  = 1'b0;
    loc      = '0;

    if (accept) begin
      res_pa_d = '0;
      res_st_d = ST_OK;
      state_d  = S_DONE;
      case (req_i.mode)
        MODE_WRITE: begin
          wr_en_o = (32'(req_i.entry_index) < 32'(STORE_WORDS));
        end
        MODE_USER, MODE_KERNEL: begin
          va_d   = req_i.virt_addr;
          user_d = (req_i.mode == MODE_USER);
          loc    = locate(cfg_i.root_ppn, va_index(req_i.virt_addr, LvlW'(LEVELS - 1)),
                          cfg_i.base_ppn);
          if ((VA_PAD_W'(req_i.virt_addr) >> VaBits) != '0) begin
            res_st_d = ST_VA_BIG;
          end else if (!loc[AW]) begin
            res_st_d = ST_OUTSIDE;
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = loc[AW-1:0];
            lvl_d     = LvlW'(LEVELS - 1);
            state_d   = S_WALK;
          end
        end
        default: begin
          res_st_d = ST_OK;
        end
      endcase
    end else if (push) begin
      state_d = S_IDLE;
    end else if (state_q == S_WALK) begin
      loc = locate(pte[PTE_PPN_LO +: PPN_W], va_index(va_q, lvl_q - 1'b1),
                   cfg_i.base_ppn);
      if (!pte[FLAG_V]) begin
        res_st_d = ST_INVALID;
        state_d  = S_DONE;
      end else if (lvl_q == '0) begin
        state_d = S_DONE;
        if (user_q && !pte[FLAG_U]) begin
          res_st_d = ST_NOT_USER;
        end else begin
          res_pa_d = {pte[PTE_PPN_LO +: PPN_W], user_q ? {OFF_W{1'b0}} : va_q[OFF_W-1:0]};
        end
      end else if (!loc[AW]) begin
        res_st_d = ST_OUTSIDE;
        state_d  = S_DONE;
      end else begin
        rd_en_o   = 1'b1;
        rd_addr_o = loc[AW-1:0];
        lvl_d     = lvl_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q    <= lvl_d;
    va_q     <= va_d;
    user_q   <= user_d;
    res_pa_q <= res_pa_d;
    res_st_q <= res_st_d;
  end

  assign res_o.valid     = push;
  assign res_o.phys_addr = res_pa_q;
  assign res_o.status    = res_st_q;

endmodule

`default_nettype wire
